@@ sv/assert_macros.svh @@
// Assertion macros used by the odometry controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/odo_pkg.sv @@
// Shared types, constants and functions of the odometry block.
package odo_pkg;

  localparam int unsigned TRIG_ITERATIONS = 24;
  localparam int unsigned TRIG_CNT_W = 6;

  localparam logic [31:0] MPT_RESET = 32'd237182;
  localparam logic [31:0] IWB_RESET = 32'd43577184;
  localparam logic [63:0] ANGLE_SCALE = 64'd349985421095;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic [63:0] VEL_SCALE = 64'd1000000;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MPT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IWB = 8'd1;

  typedef enum logic [3:0] {
    OP_WL, OP_WR, OP_TURN, OP_STEP, OP_PX, OP_PY, OP_NL, OP_DL, OP_NA, OP_DA, OP_DONE
  } op_t;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_MWAIT, ST_DWAIT} state_t;

  typedef struct packed {
    logic load;
    logic mul_start;
    logic div_start;
    logic out_load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic trig_done;
    logic out_busy;
  } sts_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'd536870912;   5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;   5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;    5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;    5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;     5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;     5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;     5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;       5'd19: v = 32'd1304;
      5'd20: v = 32'd652;        5'd21: v = 32'd326;
      5'd22: v = 32'd163;        5'd23: v = 32'd81;
      5'd24: v = 32'd41;         5'd25: v = 32'd20;
      5'd26: v = 32'd10;         5'd27: v = 32'd5;
      5'd28: v = 32'd3;          5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Clamp to the 48 bit signed range.
  function automatic logic [47:0] sat48(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = $signed({19'd0, {47{1'b1}}});
    lo = $signed({{19{1'b1}}, 47'd0});
    if (v > hi) return hi[47:0];
    if (v < lo) return lo[47:0];
    return v[47:0];
  endfunction

endpackage

@@ sv/odo_cordic.sv @@
// Iterative CORDIC that turns a binary angle into Q30 cosine and sine.
module odo_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [33:0] cos_q,
  output logic signed [33:0] sin_q
);
  import odo_pkg::*;

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [TRIG_CNT_W-1:0] it_r, it_nxt;
  logic flip_r, flip_nxt;
  logic flip_in;
  logic [31:0] ang_f;
  logic signed [33:0] xs, ys, at;

  assign flip_in = angle[31] ^ angle[30];
  assign ang_f = flip_in ? (angle + 32'h8000_0000) : angle;
  assign xs = x_r >>> it_r[4:0];
  assign ys = y_r >>> it_r[4:0];
  assign at = $signed({2'b00, atan_entry(it_r[4:0])});
  assign done = (it_r == TRIG_CNT_W'(TRIG_ITERATIONS));

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    it_nxt = it_r;
    flip_nxt = flip_r;
    if (start) begin
      x_nxt = CORDIC_START;
      y_nxt = '0;
      z_nxt = $signed({{2{ang_f[31]}}, ang_f});
      it_nxt = '0;
      flip_nxt = flip_in;
    end else if (!done) begin
      if (!z_r[33]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      it_nxt = it_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_r <= TRIG_CNT_W'(TRIG_ITERATIONS);
    end else begin
      it_r <= it_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    flip_r <= flip_nxt;
  end

  assign cos_q = flip_r ? -x_r : x_r;
  assign sin_q = flip_r ? -y_r : y_r;

endmodule

@@ sv/odo_dp.sv @@
// Odometry datapath: operand select, shared multiplier, divider and state.
module odo_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  odo_pkg::cmd_t                 cmd,
  output odo_pkg::sts_t                 sts,
  input  logic [95:0]                   in_tdata,
  input  logic                          cfg_valid,
  input  logic [odo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [191:0]                  out_tdata,
  output logic                          out_tuser
);
  import odo_pkg::*;

  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
  } wd_t;

  function automatic wd_t wheel_delta(input logic [31:0] cur, input logic [31:0] prev);
    logic signed [32:0] c;
    logic signed [32:0] p;
    logic [32:0] ac;
    logic [32:0] ap;
    logic signed [33:0] d;
    wd_t r;
    c = $signed({cur[31], cur});
    p = $signed({prev[31], prev});
    ac = c[32] ? 33'(-c) : 33'(c);
    ap = p[32] ? 33'(-p) : 33'(p);
    d = $signed({1'b0, ac}) - $signed({1'b0, ap});
    if (c[32] || (c == 33'sd0)) d = -d;
    r.neg = d[33];
    r.mag = d[33] ? 32'(-d) : 32'(d);
    return r;
  endfunction

  // Configuration and state
  logic [31:0] mpt_r, iwb_r;
  logic [31:0] left_r, right_r, elapsed_r, last_left_r, last_right_r;
  logic signed [47:0] dl_r, dr_r, acc_x_r, acc_y_r;
  logic signed [56:0] turn_r;
  logic [31:0] head_r, lin_r, ang_r;
  logic [68:0] num_r;

  // Multiplier
  logic [63:0] mul_a_r, mul_b_r, pp_r;
  logic [1:0] pp_j_r;
  logic mul_neg_r, mul_busy_r, mul_done_r;
  logic [2:0] mul_k_r;
  logic [127:0] prod_r;
  op_t mul_op_r;
  logic [63:0] op_a, op_b;
  logic op_neg;
  logic [31:0] a_part, b_part;
  logic [127:0] pp_sh;

  // Divider
  logic [31:0] rem_r, quo_r;
  logic [5:0] div_cnt_r;
  logic div_busy_r, div_done_r, div_ovf_r, div_neg_r;
  op_t div_op_r;
  logic [32:0] div_tmp;
  logic div_ge;
  logic [31:0] div_res;

  // Shared intermediates
  wd_t wd_l, wd_r;
  logic signed [48:0] wsum, wdiff, fwd;
  logic [48:0] fwd_mag, diff_mag;
  logic [56:0] turn_mag;
  logic signed [33:0] cos_q, sin_q;
  logic [33:0] cos_mag, sin_mag;
  logic trig_done;
  logic signed [65:0] pos_sum_x, pos_sum_y;
  logic out_valid_r;
  logic [191:0] out_data_r;
  logic out_flag_r;

  odo_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.load),
    .angle (head_r),
    .done  (trig_done),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  assign wd_l = wheel_delta(left_r, last_left_r);
  assign wd_r = wheel_delta(right_r, last_right_r);
  assign wsum = 49'(dl_r) + 49'(dr_r);
  // add one before the shift when negative so the halving truncates toward zero
  assign fwd = (wsum + $signed({48'd0, wsum[48]})) >>> 1;
  assign wdiff = 49'(dr_r) - 49'(dl_r);
  assign fwd_mag = fwd[48] ? 49'(-fwd) : 49'(fwd);
  assign diff_mag = wdiff[48] ? 49'(-wdiff) : 49'(wdiff);
  assign turn_mag = turn_r[56] ? 57'(-turn_r) : 57'(turn_r);
  assign cos_mag = cos_q[33] ? 34'(-cos_q) : 34'(cos_q);
  assign sin_mag = sin_q[33] ? 34'(-sin_q) : 34'(sin_q);

  always_comb begin
    op_a = '0;
    op_b = '0;
    op_neg = 1'b0;
    case (cmd.op)
      OP_WL: begin
        op_a = {32'd0, wd_l.mag}; op_b = {32'd0, mpt_r}; op_neg = wd_l.neg;
      end
      OP_WR: begin
        op_a = {32'd0, wd_r.mag}; op_b = {32'd0, mpt_r}; op_neg = wd_r.neg;
      end
      OP_TURN: begin
        op_a = 64'(diff_mag); op_b = {32'd0, iwb_r}; op_neg = wdiff[48];
      end
      OP_STEP: begin
        op_a = 64'(turn_mag); op_b = ANGLE_SCALE; op_neg = turn_r[56];
      end
      OP_PX: begin
        op_a = 64'(fwd_mag); op_b = 64'(cos_mag); op_neg = fwd[48] ^ cos_q[33];
      end
      OP_PY: begin
        op_a = 64'(fwd_mag); op_b = 64'(sin_mag); op_neg = fwd[48] ^ sin_q[33];
      end
      OP_NL: begin
        op_a = 64'(fwd_mag); op_b = VEL_SCALE;
      end
      OP_NA: begin
        op_a = 64'(turn_mag); op_b = VEL_SCALE;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  assign a_part = mul_k_r[0] ? mul_a_r[63:32] : mul_a_r[31:0];
  assign b_part = mul_k_r[1] ? mul_b_r[63:32] : mul_b_r[31:0];

  always_comb begin
    case (pp_j_r)
      2'd0: pp_sh = {64'd0, pp_r};
      2'd3: pp_sh = {pp_r, 64'd0};
      default: pp_sh = {32'd0, pp_r, 32'd0};
    endcase
  end

  assign pos_sum_x = 66'(acc_x_r) + 66'($signed(prod_r[79:30]));
  assign pos_sum_y = 66'(acc_y_r) + 66'($signed(prod_r[79:30]));

  assign div_tmp = {rem_r, quo_r[31]};
  assign div_ge = div_tmp >= {1'b0, elapsed_r};

  always_comb begin
    if (elapsed_r == 32'd0) begin
      div_res = '0;
    end else if (div_ovf_r || quo_r[31]) begin
      div_res = div_neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      div_res = div_neg_r ? -quo_r : quo_r;
    end
  end

  // Multiplier sequence: four partial products, then sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mul_done_r <= 1'b0;
      mul_k_r <= '0;
    end else begin
      mul_done_r <= 1'b0;
      if (cmd.mul_start) begin
        mul_busy_r <= 1'b1;
        mul_k_r <= '0;
      end else if (mul_busy_r) begin
        mul_k_r <= mul_k_r + 1'b1;
        if (mul_k_r == 3'd5) begin
          mul_busy_r <= 1'b0;
          mul_done_r <= 1'b1;
        end
      end
    end
    if (cmd.mul_start) begin
      mul_a_r <= op_a;
      mul_b_r <= op_b;
      mul_neg_r <= op_neg;
      mul_op_r <= cmd.op;
      prod_r <= '0;
    end else if (mul_busy_r) begin
      if (mul_k_r < 3'd4) begin
        pp_r <= 64'(a_part) * 64'(b_part);
        pp_j_r <= mul_k_r[1:0];
      end
      if (mul_k_r >= 3'd1 && mul_k_r <= 3'd4) begin
        prod_r <= prod_r + pp_sh;
      end else if (mul_k_r == 3'd5 && mul_neg_r) begin
        prod_r <= -prod_r;
      end
    end
  end

  // Divider: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
      div_cnt_r <= '0;
    end else begin
      div_done_r <= 1'b0;
      if (cmd.div_start) begin
        div_busy_r <= 1'b1;
        div_cnt_r <= '0;
      end else if (div_busy_r) begin
        div_cnt_r <= div_cnt_r + 1'b1;
        if (div_cnt_r == 6'd31) begin
          div_busy_r <= 1'b0;
          div_done_r <= 1'b1;
        end
      end
    end
    if (cmd.div_start) begin
      rem_r <= num_r[63:32];
      quo_r <= num_r[31:0];
      div_ovf_r <= num_r[68:32] >= {5'd0, elapsed_r};
      div_neg_r <= (cmd.op == OP_DL) ? fwd[48] : turn_r[56];
      div_op_r <= cmd.op;
    end else if (div_busy_r) begin
      rem_r <= div_ge ? 32'(div_tmp - {1'b0, elapsed_r}) : div_tmp[31:0];
      quo_r <= {quo_r[30:0], div_ge};
    end
  end

  // Architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpt_r <= MPT_RESET;
      iwb_r <= IWB_RESET;
      last_left_r <= '0;
      last_right_r <= '0;
      acc_x_r <= '0;
      acc_y_r <= '0;
      head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_MPT) mpt_r <= cfg_data;
        else if (cfg_index == CFG_IWB) iwb_r <= cfg_data;
      end
      if (mul_done_r) begin
        case (mul_op_r)
          OP_STEP: head_r <= head_r + prod_r[64:33];
          OP_PX: acc_x_r <= sat48(pos_sum_x);
          OP_PY: acc_y_r <= sat48(pos_sum_y);
          default: ;
        endcase
      end
      if (cmd.out_load) begin
        last_left_r <= left_r;
        last_right_r <= right_r;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.load) begin
      left_r <= in_tdata[31:0];
      right_r <= in_tdata[63:32];
      elapsed_r <= in_tdata[95:64];
    end
    if (mul_done_r) begin
      case (mul_op_r)
        OP_WL: dl_r <= sat48(prod_r[65:0]);
        OP_WR: dr_r <= sat48(prod_r[65:0]);
        OP_TURN: turn_r <= prod_r[80:24];
        OP_NL, OP_NA: num_r <= prod_r[76:8];
        default: ;
      endcase
    end
    if (div_done_r) begin
      if (div_op_r == OP_DL) lin_r <= div_res;
      else ang_r <= div_res;
    end
    if (cmd.out_load) begin
      out_data_r <= {ang_r, lin_r, head_r, acc_y_r, acc_x_r};
      out_flag_r <= (elapsed_r == 32'd0);
    end
  end

  assign sts.mul_done = mul_done_r;
  assign sts.div_done = div_done_r;
  assign sts.trig_done = trig_done;
  assign sts.out_busy = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_flag_r;

endmodule

@@ sv/odo_ctrl.sv @@
// Odometry controller: steps the datapath through one sample's operations.
module odo_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  odo_pkg::sts_t sts,
  output odo_pkg::cmd_t cmd
);
  import odo_pkg::*;
  `include "assert_macros.svh"

  state_t state_r, state_nxt;
  op_t op_r, op_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r <= OP_WL;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    cmd = '0;
    cmd.op = op_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          op_nxt = OP_WL;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        case (op_r)
          OP_DONE: begin
            if (!sts.out_busy) begin
              cmd.out_load = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          OP_DL, OP_DA: begin
            cmd.div_start = 1'b1;
            state_nxt = ST_DWAIT;
          end
          OP_PX, OP_PY: begin
            // hold until the trig unit has settled
            if (sts.trig_done) begin
              cmd.mul_start = 1'b1;
              state_nxt = ST_MWAIT;
            end
          end
          default: begin
            cmd.mul_start = 1'b1;
            state_nxt = ST_MWAIT;
          end
        endcase
      end
      ST_MWAIT: begin
        if (sts.mul_done) begin
          op_nxt = op_t'(op_r + 4'd1);
          state_nxt = ST_ISSUE;
        end
      end
      ST_DWAIT: begin
        if (sts.div_done) begin
          op_nxt = op_t'(op_r + 4'd1);
          state_nxt = ST_ISSUE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `ASSERT_NEXT(a_load_issues, cmd.load, (state_r == ST_ISSUE) && (op_r == OP_WL), "load must start the op sequence")
  `ASSERT_IMPL(a_out_free, cmd.out_load, !sts.out_busy && (op_r == OP_DONE), "output loaded while busy")
  `ASSERT_NEXT(a_mul_wait, (state_r == ST_MWAIT) && sts.mul_done, state_r == ST_ISSUE, "mul done not taken")
  `ASSERT_IMPL(a_trig_ready, cmd.mul_start && (op_r == OP_PX || op_r == OP_PY), sts.trig_done, "pose step before trig done")

endmodule

@@ sv/diff_drive_odometry.sv @@
// Differential-drive wheel odometry top level.
// Each input word carries cumulative left and right encoder counts and the
// microseconds since the previous word; each one yields exactly one result
// word with the updated pose (Q24.24 metres, saturating), the heading as a
// 32 bit binary angle (wraps), and forward and yaw velocities in Q16.16
// (saturating, forced to zero with the flag in tuser when the elapsed time
// is zero). Each sample is loaded, then passes through eight products on a
// shared 32x32 multiplier and two 32-step velocity divisions before its
// result is loaded; the 24-step CORDIC for the old heading runs alongside
// the first products, and the next sample is accepted only once the result
// is loaded. A new sample is taken while the previous result still waits
// in the output register.
// Configuration writes are always accepted (cfg_ready is tied high); index 0
// is metres per tick, index 1 the inverse wheel base, other indexes are
// ignored. Write them only while idle.
module diff_drive_odometry (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [95:0]                   in_tdata,   // left_count, right_count, elapsed_us
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // pos_x, pos_y, heading, linear_velocity, angular_velocity
  output logic [191:0]                  out_tdata,
  output logic                          out_tuser,  // zero_time_flag
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [odo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import odo_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  odo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  odo_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
